// ----- src/bptc_pkg.sv -----
package bptc_pkg;

    // stream payload, calibration and register-port widths
    localparam int IN_W   = 48;
    localparam int OUT_W  = 32;
    localparam int CAL_W  = 16;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // compensation constants
    localparam int TEMP_REF  = 2000;
    localparam int TEMP_LOW  = -1500;
    localparam int P_MIN     = 1000;
    localparam int P_MAX     = 120000;
    localparam int T_MIN     = -4000;
    localparam int T_MAX     = 8500;

    // calibration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } reg_idx_t;

endpackage

// ----- src/baro_pressure_temp_compensation.sv -----
// Barometric pressure and temperature compensation, second-order scheme.
// Input stream: one transfer carries a raw pressure conversion and a raw
// temperature conversion. Output stream: one transfer per input with the
// pressure in pascals, the temperature in hundredths of a degree and a
// saturation flag on m_tuser.
// The six calibration words sit behind an APB-style port at byte addresses
// 0x00..0x14; write them while the stream is idle. pready is always high.
// Datapath: nine register stages. One transfer in per cycle is sustained
// while m_tready stays high. A result shows on m_tvalid once it has passed
// from the stage 1 register through the stage 9 output register.
// The product of raw pressure and sensitivity, held in 70 bits, is split into
// two partial products and summed in the next stage, which sets the depth.
// Each stage holds its own valid bit and loads when it is empty or its
// successor loads, so bubbles fold up while m_tready is low and the block
// keeps taking inputs until every stage is full; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and the calibration
// words to zero.
module baro_pressure_temp_compensation (
    input  logic                          aclk,
    input  logic                          aresetn,
    // [23:0] raw_pressure, [47:24] raw_temperature
    input  logic [bptc_pkg::IN_W-1:0]     s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [16:0] pressure_pa, [31:17] temp_centi
    output logic [bptc_pkg::OUT_W-1:0]    m_tdata,
    // [0] out_of_range
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bptc_pkg::ADDR_W-1:0]   paddr,
    input  logic [bptc_pkg::DATA_W-1:0]   pwdata,
    output logic [bptc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import bptc_pkg::*;

    localparam int NS = 9;

    // calibration registers
    logic [CAL_W-1:0] cal1_reg, cal2_reg, cal3_reg, cal4_reg, cal5_reg, cal6_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal1_reg <= '0;
            cal2_reg <= '0;
            cal3_reg <= '0;
            cal4_reg <= '0;
            cal5_reg <= '0;
            cal6_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_C1:  cal1_reg <= pwdata[CAL_W-1:0];
                REG_C2:  cal2_reg <= pwdata[CAL_W-1:0];
                REG_C3:  cal3_reg <= pwdata[CAL_W-1:0];
                REG_C4:  cal4_reg <= pwdata[CAL_W-1:0];
                REG_C5:  cal5_reg <= pwdata[CAL_W-1:0];
                REG_C6:  cal6_reg <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_C1:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal1_reg};
            REG_C2:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal2_reg};
            REG_C3:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal3_reg};
            REG_C4:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal4_reg};
            REG_C5:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal5_reg};
            REG_C6:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal6_reg};
            default: prdata = '0;
        endcase
    end

    // per-stage valid and load enable
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // no transfer is taken while reset is held
    assign s_tready = en[0] && aresetn;
    assign m_tvalid = vld_reg[NS-1];

    // stage 1: temperature difference
    logic        [23:0] s1_d1_reg, s1_d1_next;
    logic signed [24:0] s1_dt_reg, s1_dt_next;
    // stage 2: products of dt
    logic        [23:0] s2_d1_reg;
    logic signed [41:0] s2_tc_reg, s2_tc_next;
    logic signed [49:0] s2_dd_reg, s2_dd_next;
    logic signed [41:0] s2_c4_reg, s2_c4_next;
    logic signed [41:0] s2_c3_reg, s2_c3_next;
    // stage 3: first-order terms
    logic        [23:0] s3_d1_reg;
    logic signed [19:0] s3_t1_reg, s3_t1_next;
    logic signed [18:0] s3_a_reg, s3_a_next;
    logic signed [19:0] s3_b_reg, s3_b_next;
    logic        [18:0] s3_t2_reg, s3_t2_next;
    logic signed [36:0] s3_off1_reg, s3_off1_next;
    logic signed [36:0] s3_sens1_reg, s3_sens1_next;
    logic               s3_lo_reg, s3_lo_next;
    logic               s3_vlo_reg, s3_vlo_next;
    // stage 4: squares and final temperature
    logic        [23:0] s4_d1_reg;
    logic signed [37:0] s4_q1_reg, s4_q1_next;
    logic signed [39:0] s4_q2_reg, s4_q2_next;
    logic signed [20:0] s4_temp_reg, s4_temp_next;
    logic signed [36:0] s4_off1_reg;
    logic signed [36:0] s4_sens1_reg;
    logic               s4_lo_reg;
    logic               s4_vlo_reg;
    // stage 5: second-order corrections, temperature clamp
    logic        [23:0] s5_d1_reg;
    logic        [43:0] s5_off2_reg, s5_off2_next;
    logic        [43:0] s5_sens2_reg, s5_sens2_next;
    logic signed [36:0] s5_off1_reg;
    logic signed [36:0] s5_sens1_reg;
    logic        [14:0] s5_temp_reg, s5_temp_next;
    logic               s5_tflag_reg, s5_tflag_next;
    // stage 6: corrected offset and sensitivity
    logic        [23:0] s6_d1_reg;
    logic signed [43:0] s6_off_reg, s6_off_next;
    logic signed [43:0] s6_sens_reg, s6_sens_next;
    logic        [14:0] s6_temp_reg;
    logic               s6_tflag_reg;
    // stage 7: partial products of d1 * sens
    logic        [45:0] s7_pl_reg, s7_pl_next;
    logic signed [46:0] s7_ph_reg, s7_ph_next;
    logic signed [43:0] s7_off_reg;
    logic        [14:0] s7_temp_reg;
    logic               s7_tflag_reg;
    // stage 8: full product
    logic signed [69:0] s8_prod_reg, s8_prod_next;
    logic signed [43:0] s8_off_reg;
    logic        [14:0] s8_temp_reg;
    logic               s8_tflag_reg;
    // stage 9: output register
    logic        [16:0] s9_pres_reg, s9_pres_next;
    logic        [14:0] s9_temp_reg;
    logic               s9_flag_reg, s9_flag_next;

    logic signed [18:0] x;
    logic        [43:0] q1e, q2e, five_q1, seven_q2, eleven_q2;
    logic signed [49:0] y;
    logic signed [34:0] p;
    logic               pflag;

    always_comb begin
        s1_d1_next = s_tdata[23:0];
        s1_dt_next = $signed({1'b0, s_tdata[47:24]}) - $signed({1'b0, cal5_reg, 8'h00});

        s2_tc_next = s1_dt_reg * $signed({1'b0, cal6_reg});
        s2_dd_next = s1_dt_reg * s1_dt_reg;
        s2_c4_next = s1_dt_reg * $signed({1'b0, cal4_reg});
        s2_c3_next = s1_dt_reg * $signed({1'b0, cal3_reg});

        x             = $signed(s2_tc_reg[41:23]);
        s3_a_next     = x;
        s3_lo_next    = x[18];
        s3_t1_next    = $signed({x[18], x}) + 20'(TEMP_REF);
        s3_b_next     = s3_t1_next - 20'(TEMP_LOW);
        s3_vlo_next   = s3_t1_next < TEMP_LOW;
        s3_t2_next    = s2_dd_reg[49:31];
        s3_off1_next  = $signed({5'b0, cal2_reg, 16'h0000})
                      + $signed({{2{s2_c4_reg[41]}}, s2_c4_reg[41:7]});
        s3_sens1_next = $signed({6'b0, cal1_reg, 15'h0000})
                      + $signed({{3{s2_c3_reg[41]}}, s2_c3_reg[41:8]});

        s4_q1_next   = s3_a_reg * s3_a_reg;
        s4_q2_next   = s3_b_reg * s3_b_reg;
        s4_temp_next = $signed({s3_t1_reg[19], s3_t1_reg})
                     - $signed({2'b00, s3_lo_reg ? s3_t2_reg : 19'd0});

        // squares are never negative, so plain shifts are floor divisions
        q1e       = 44'(s4_q1_reg);
        q2e       = 44'(s4_q2_reg);
        five_q1   = (q1e << 2) + q1e;
        seven_q2  = (q2e << 3) - q2e;
        eleven_q2 = (q2e << 3) + (q2e << 1) + q2e;
        s5_off2_next  = (s4_lo_reg ? (five_q1 >> 1) : 44'd0)
                      + (s4_vlo_reg ? seven_q2 : 44'd0);
        s5_sens2_next = (s4_lo_reg ? (five_q1 >> 2) : 44'd0)
                      + (s4_vlo_reg ? (eleven_q2 >> 1) : 44'd0);
        s5_tflag_next = 1'b1;
        if (s4_temp_reg < T_MIN) begin
            s5_temp_next = 15'(T_MIN);
        end else if (s4_temp_reg > T_MAX) begin
            s5_temp_next = 15'(T_MAX);
        end else begin
            s5_temp_next  = s4_temp_reg[14:0];
            s5_tflag_next = 1'b0;
        end

        s6_off_next  = $signed({{7{s5_off1_reg[36]}}, s5_off1_reg}) - $signed(s5_off2_reg);
        s6_sens_next = $signed({{7{s5_sens1_reg[36]}}, s5_sens1_reg}) - $signed(s5_sens2_reg);

        // split sens into an unsigned low half and a signed high half
        s7_pl_next = s6_d1_reg * s6_sens_reg[21:0];
        s7_ph_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[43:22]);

        s8_prod_next = $signed({s7_ph_reg[46], s7_ph_reg, 22'd0})
                     + $signed({24'h000000, s7_pl_reg});

        y            = $signed({s8_prod_reg[69], s8_prod_reg[69:21]})
                     - $signed({{6{s8_off_reg[43]}}, s8_off_reg});
        p            = y[49:15];
        pflag        = 1'b1;
        if (p < P_MIN) begin
            s9_pres_next = 17'(P_MIN);
        end else if (p > P_MAX) begin
            s9_pres_next = 17'(P_MAX);
        end else begin
            s9_pres_next = p[16:0];
            pflag        = 1'b0;
        end
        s9_flag_next = pflag || s8_tflag_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_d1_reg <= s1_d1_next;
            s1_dt_reg <= s1_dt_next;
        end
        if (en[1]) begin
            s2_d1_reg <= s1_d1_reg;
            s2_tc_reg <= s2_tc_next;
            s2_dd_reg <= s2_dd_next;
            s2_c4_reg <= s2_c4_next;
            s2_c3_reg <= s2_c3_next;
        end
        if (en[2]) begin
            s3_d1_reg    <= s2_d1_reg;
            s3_t1_reg    <= s3_t1_next;
            s3_a_reg     <= s3_a_next;
            s3_b_reg     <= s3_b_next;
            s3_t2_reg    <= s3_t2_next;
            s3_off1_reg  <= s3_off1_next;
            s3_sens1_reg <= s3_sens1_next;
            s3_lo_reg    <= s3_lo_next;
            s3_vlo_reg   <= s3_vlo_next;
        end
        if (en[3]) begin
            s4_d1_reg    <= s3_d1_reg;
            s4_q1_reg    <= s4_q1_next;
            s4_q2_reg    <= s4_q2_next;
            s4_temp_reg  <= s4_temp_next;
            s4_off1_reg  <= s3_off1_reg;
            s4_sens1_reg <= s3_sens1_reg;
            s4_lo_reg    <= s3_lo_reg;
            s4_vlo_reg   <= s3_vlo_reg;
        end
        if (en[4]) begin
            s5_d1_reg    <= s4_d1_reg;
            s5_off2_reg  <= s5_off2_next;
            s5_sens2_reg <= s5_sens2_next;
            s5_off1_reg  <= s4_off1_reg;
            s5_sens1_reg <= s4_sens1_reg;
            s5_temp_reg  <= s5_temp_next;
            s5_tflag_reg <= s5_tflag_next;
        end
        if (en[5]) begin
            s6_d1_reg    <= s5_d1_reg;
            s6_off_reg   <= s6_off_next;
            s6_sens_reg  <= s6_sens_next;
            s6_temp_reg  <= s5_temp_reg;
            s6_tflag_reg <= s5_tflag_reg;
        end
        if (en[6]) begin
            s7_pl_reg    <= s7_pl_next;
            s7_ph_reg    <= s7_ph_next;
            s7_off_reg   <= s6_off_reg;
            s7_temp_reg  <= s6_temp_reg;
            s7_tflag_reg <= s6_tflag_reg;
        end
        if (en[7]) begin
            s8_prod_reg  <= s8_prod_next;
            s8_off_reg   <= s7_off_reg;
            s8_temp_reg  <= s7_temp_reg;
            s8_tflag_reg <= s7_tflag_reg;
        end
        if (en[8]) begin
            s9_pres_reg <= s9_pres_next;
            s9_temp_reg <= s8_temp_reg;
            s9_flag_reg <= s9_flag_next;
        end
    end

    assign m_tdata = {s9_temp_reg, s9_pres_reg};
    assign m_tuser = s9_flag_reg;

    // input backs up only when every stage holds an item and the sink stalls
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg) && !m_tready)
        else $error("input stalled while the pipeline has room");

    a_pres_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:0] >= P_MIN) && (m_tdata[16:0] <= P_MAX))
        else $error("pressure outside saturation range");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:17]) >= T_MIN) && ($signed(m_tdata[31:17]) <= T_MAX))
        else $error("temperature outside saturation range");

    a_flag_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[16:0] == 17'(P_MIN)) || (m_tdata[16:0] == 17'(P_MAX))
            || (m_tdata[31:17] == 15'(T_MIN)) || (m_tdata[31:17] == 15'(T_MAX)))
        else $error("saturation flag without a clamped result");

endmodule

// ----- tb/baro_pressure_temp_compensation_test.sv -----
module baro_pressure_temp_compensation_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bptc_pkg::*;

    localparam int RESET_CYCLES     = 6;
    localparam int MAX_IDLE         = 17;
    localparam int PIPE_SETTLE      = 12;
    localparam int LONG_HOLD        = 150;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int MAX_REPORTS      = 10;
    localparam int NUM_CAL          = 6;
    localparam int FIRST_UNMAPPED   = 6;
    localparam int NUM_PHASES       = 8;
    localparam int HOLD_PHASE       = 2;
    localparam int PAUSE_PHASE      = 5;
    localparam int NUM_DIRECTED     = 19;
    localparam logic [23:0] RAW_MAX = 24'hFFFFFF;

    // calibration sets
    localparam logic [2:0] CAL_RESET   = 3'd0;
    localparam logic [2:0] CAL_TYPICAL = 3'd1;
    localparam logic [2:0] CAL_MAX     = 3'd2;
    localparam logic [2:0] CAL_ZERO    = 3'd3;
    localparam logic [2:0] CAL_ALT_A   = 3'd4;
    localparam logic [2:0] CAL_ALT_B   = 3'd5;
    localparam logic [2:0] CAL_RAND_A  = 3'd6;
    localparam logic [2:0] CAL_RAND_B  = 3'd7;

    typedef struct packed {
        logic [16:0] pressure_pa;
        logic [14:0] temp_centi;
        logic        out_of_range;
    } reading_t;

    typedef struct packed {
        logic [2:0]  cal_set;
        logic [23:0] raw_p;
        logic [23:0] raw_t;
        logic        typed;
        reading_t    want;
    } stim_row_t;

    // zero calibration: pressure sits at P_MIN, temperature stays at TEMP_REF
    localparam reading_t AT_RESET  = '{17'd1000, 15'd2000, 1'b1};
    localparam reading_t PREDICTED = '0;

    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{CAL_RESET,   24'd0,        24'd0,        1'b1, AT_RESET},
        '{CAL_RESET,   RAW_MAX,      RAW_MAX,      1'b1, AT_RESET},
        '{CAL_RESET,   RAW_MAX,      24'd0,        1'b1, AT_RESET},
        '{CAL_RESET,   24'd0,        RAW_MAX,      1'b1, AT_RESET},
        '{CAL_RESET,   24'hAAAAAA,   24'h555555,   1'b1, AT_RESET},
        '{CAL_TYPICAL, 24'd9085466,  24'd8569150,  1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd9085466,  24'd8566784,  1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd9085466,  24'd8566783,  1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd9085466,  24'd7529768,  1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd9085466,  24'd7529767,  1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd9085466,  24'd7000000,  1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd9085466,  24'd0,        1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd9085466,  RAW_MAX,      1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd9085466,  24'd10500000, 1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd0,        24'd8569150,  1'b0, PREDICTED},
        '{CAL_TYPICAL, RAW_MAX,      24'd8569150,  1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd3000000,  24'd8569150,  1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'd12000000, 24'd6000000,  1'b0, PREDICTED},
        '{CAL_TYPICAL, 24'h555555,   24'hAAAAAA,   1'b0, PREDICTED}
    };

    localparam logic [2:0] PHASE_SETS [NUM_PHASES] = '{
        CAL_TYPICAL, CAL_MAX, CAL_ALT_A, CAL_ALT_B,
        CAL_RAND_A, CAL_ZERO, CAL_RAND_B, CAL_TYPICAL
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [DATA_W-1:0]    pwdata   = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    logic [CAL_W-1:0]     cal_words [NUM_CAL];
    logic [CAL_W-1:0]     cal_sets [8][NUM_CAL];
    reading_t             expected_readings [$];
    int                   mismatches   = 0;
    int                   stall_cycles = 0;
    bit                   rx_hold_req  = 1'b0;
    bit                   rx_steady    = 1'b0;
    bit                   tx_steady    = 1'b0;

    always #5 aclk = ~aclk;

    baro_pressure_temp_compensation i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // first-order compensation plus the cold corrections, saturated
    function automatic reading_t compensate_reading(logic [23:0] raw_p, logic [23:0] raw_t);
        longint d1, d2, dt, temp, off, sens, t2, off2, sens2, p, q;
        reading_t r;
        d1 = longint'(raw_p);
        d2 = longint'(raw_t);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        r.out_of_range = 1'b0;
        dt = d2 - (longint'(cal_words[REG_C5]) <<< 8);
        temp = TEMP_REF + ((dt * longint'(cal_words[REG_C6])) >>> 23);
        // thresholds use the first-order temperature
        if (temp < TEMP_REF) begin
            q = (temp - TEMP_REF) * (temp - TEMP_REF);
            t2 = (dt * dt) >>> 31;
            off2 = (5 * q) >>> 1;
            sens2 = (5 * q) >>> 2;
        end
        if (temp < TEMP_LOW) begin
            q = (temp - TEMP_LOW) * (temp - TEMP_LOW);
            off2 += 7 * q;
            sens2 += (11 * q) >>> 1;
        end
        off = (longint'(cal_words[REG_C2]) <<< 16)
            + ((longint'(cal_words[REG_C4]) * dt) >>> 7) - off2;
        sens = (longint'(cal_words[REG_C1]) <<< 15)
             + ((longint'(cal_words[REG_C3]) * dt) >>> 8) - sens2;
        temp -= t2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (p < P_MIN) begin
            p = P_MIN;
            r.out_of_range = 1'b1;
        end else if (p > P_MAX) begin
            p = P_MAX;
            r.out_of_range = 1'b1;
        end
        if (temp < T_MIN) begin
            temp = T_MIN;
            r.out_of_range = 1'b1;
        end else if (temp > T_MAX) begin
            temp = T_MAX;
            r.out_of_range = 1'b1;
        end
        r.pressure_pa = p[16:0];
        r.temp_centi = temp[14:0];
        return r;
    endfunction

    function automatic logic [23:0] pick_raw_pressure();
        if ($urandom_range(0, 1) == 0)
            return 24'($urandom_range(0, 32'(RAW_MAX)));
        return 24'($urandom_range(3000000, 12000000));
    endfunction

    // mostly near the reference temperature so the cold branches get hit
    function automatic logic [23:0] pick_raw_temp();
        int center, span, v;
        if ($urandom_range(0, 9) < 4)
            return 24'($urandom_range(0, 32'(RAW_MAX)));
        center = int'(cal_words[REG_C5]) << 8;
        span = 1 << (10 + 2 * $urandom_range(0, 6));
        v = center + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > int'(RAW_MAX))
            v = int'(RAW_MAX);
        return 24'(v);
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    task automatic apb_access(input bit wr, input int idx, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        rdata = prdata;
        if (wr && idx < NUM_CAL)
            cal_words[idx] = wdata[CAL_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_cal_set(input logic [2:0] set_id);
        logic [DATA_W-1:0] rd;
        for (int i = REG_C1; i <= REG_C6; i++)
            apb_access(1'b1, i, {16'($urandom), cal_sets[set_id][i]}, rd);
        // writes past the last register must not land anywhere
        apb_access(1'b1, FIRST_UNMAPPED + int'($urandom_range(0, 1)), $urandom, rd);
        for (int i = REG_C1; i <= REG_C6; i++) begin
            apb_access(1'b0, i, '0, rd);
            if (rd !== {16'h0, cal_words[i]})
                note_mismatch("register readback", longint'(cal_words[i]), longint'(rd));
        end
    endtask

    task automatic send_reading(input logic [23:0] raw_p, input logic [23:0] raw_t,
                                input reading_t want, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {raw_t, raw_p};
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_readings.push_back(want);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_readings.size() == 0) begin
                note_mismatch("transfer with nothing pending", 0, longint'(m_tdata));
            end else begin
                want = expected_readings.pop_front();
                if (m_tdata[16:0] !== want.pressure_pa)
                    note_mismatch("pressure_pa", longint'(want.pressure_pa),
                                  longint'(m_tdata[16:0]));
                if (m_tdata[31:17] !== want.temp_centi)
                    note_mismatch("temp_centi", longint'($signed(want.temp_centi)),
                                  longint'($signed(m_tdata[31:17])));
                if (m_tuser !== want.out_of_range)
                    note_mismatch("out_of_range", longint'(want.out_of_range),
                                  longint'(m_tuser));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)
            || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        int n, served;
        served = 0;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            if (served % 32 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
            n = rx_steady ? 0 : int'($urandom_range(0, MAX_IDLE));
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            served++;
        end
    end

    initial begin
        logic [2:0]  active_set;
        logic [23:0] rp, rt;
        int gap;

        for (int i = REG_C1; i <= REG_C6; i++) begin
            cal_words[i] = '0;
            cal_sets[CAL_RESET][i] = '0;
            cal_sets[CAL_MAX][i] = 16'hFFFF;
            cal_sets[CAL_ZERO][i] = '0;
            cal_sets[CAL_ALT_A][i] = (i % 2 == 0) ? 16'hFFFF : 16'h0000;
            cal_sets[CAL_ALT_B][i] = (i % 2 == 0) ? 16'h0000 : 16'hFFFF;
            cal_sets[CAL_RAND_A][i] = 16'($urandom);
            cal_sets[CAL_RAND_B][i] = 16'($urandom);
        end
        cal_sets[CAL_TYPICAL] = '{16'd40127, 16'd36924, 16'd23317,
                                  16'd23282, 16'd33464, 16'd28312};
        // keep one random set close to real parts
        cal_sets[CAL_RAND_B][REG_C5] = 16'($urandom_range(28000, 38000));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        active_set = CAL_RESET;
        foreach (DIRECTED_ROWS[k]) begin
            if (DIRECTED_ROWS[k].cal_set != active_set) begin
                settle();
                active_set = DIRECTED_ROWS[k].cal_set;
                load_cal_set(active_set);
            end
            send_reading(DIRECTED_ROWS[k].raw_p, DIRECTED_ROWS[k].raw_t,
                         DIRECTED_ROWS[k].typed ? DIRECTED_ROWS[k].want
                         : compensate_reading(DIRECTED_ROWS[k].raw_p, DIRECTED_ROWS[k].raw_t),
                         int'($urandom_range(0, MAX_IDLE)));
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            load_cal_set(PHASE_SETS[ph]);
            if (ph == HOLD_PHASE)
                rx_hold_req = 1'b1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 40 == 0)
                    tx_steady = ($urandom_range(0, 2) == 0);
                // keep offering while the result side is held off
                if (ph == HOLD_PHASE && n < 60)
                    tx_steady = 1'b1;
                if (ph == PAUSE_PHASE && n == RANDOM_PER_PHASE / 2)
                    settle();
                rp = pick_raw_pressure();
                rt = pick_raw_temp();
                gap = tx_steady ? 0 : int'($urandom_range(0, MAX_IDLE));
                send_reading(rp, rt, compensate_reading(rp, rt), gap);
            end
        end

        settle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/bptc_pkg.sv
src/baro_pressure_temp_compensation.sv
tb/baro_pressure_temp_compensation_test.sv
